// File: rtl/itr_pkg.sv
// ----------------------------------------------------------------------------
// itr_pkg: shared definitions for the integer to text converter
// Word size, character codes, sequencer states and the digit encoder.
// ----------------------------------------------------------------------------
package itr_pkg;

   // integer word and derived widths
   localparam int WORD_BITS  = 32;
   localparam int CNT_BITS   = $clog2(WORD_BITS + 1);
   localparam int IDX_BITS   = $clog2(WORD_BITS);
   localparam int RADIX_BITS = 6;
   localparam int CHAR_BITS  = 7;

   // base limits and fixed characters
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
   localparam logic [CHAR_BITS-1:0]  SIGN_CHAR   = CHAR_BITS'(45);
   localparam logic [CHAR_BITS-1:0]  NUL_CHAR    = CHAR_BITS'(0);

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIVIDE = 5'b00010,
      ST_SIGN   = 5'b00100,
      ST_EMIT   = 5'b01000,
      ST_TERM   = 5'b10000
   } state_type;

   // digit value to lower-case ascii
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
      logic [CHAR_BITS-1:0] dx;
      dx = CHAR_BITS'(d);
      if (d < RADIX_BITS'(10)) begin
         digit_char = CHAR_BITS'(48) + dx;
      end else begin
         digit_char = CHAR_BITS'(87) + dx;
      end
   endfunction

endpackage

// File: rtl/integer_to_text_radix_top.sv
// ----------------------------------------------------------------------------
// integer_to_text_radix_top: signed integer to text in a configurable base
// Restoring divider under a small sequencer, digit store, character output.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the text is out. Each character appears for one cycle with rsp_valid
// and cannot be held off, so the receiver must take every beat as it comes.
// The text is '-' for a negative value, the digits most significant first,
// then a NUL with rsp_last set. A base outside 2 to 36 gives only the NUL.
// Each digit takes one bit-serial division pass over all WORD_BITS bits through
// the shared 7-bit subtract/compare unit; the characters then follow at one
// per cycle. Busy stays high through the divisions and the sign and digit
// beats; an invalid base goes straight to the terminator.
// The NUL beat comes out in the same cycle that busy falls, and the next item can
// be taken in that same cycle. The character beats follow the last division.
module integer_to_text_radix_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [itr_pkg::WORD_BITS-1:0] req_value,
   input  logic                              csr_write_enable,
   input  logic [itr_pkg::RADIX_BITS-1:0]    csr_write_data,
   output logic                              rsp_valid,
   output logic [itr_pkg::CHAR_BITS-1:0]     rsp_character,
   output logic                              rsp_last
);
   import itr_pkg::*;

   state_type                 state_ff, state_in;
   logic [RADIX_BITS-1:0]     radix_ff;
   logic [WORD_BITS-1:0]      quo_ff, quo_in;
   logic [RADIX_BITS-1:0]     rem_ff, rem_in;
   logic [IDX_BITS-1:0]       bit_ff, bit_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]      rsp_char_ff, rsp_char_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [RADIX_BITS-1:0]     digit_mem [WORD_BITS];
   logic [RADIX_BITS-1:0]     digit_ff;

   logic                      accept;
   logic                      radix_ok;
   logic [RADIX_BITS:0]       trial;
   logic                      ge;
   logic [RADIX_BITS:0]       diff;
   logic [RADIX_BITS-1:0]     digit_val;
   logic                      digit_done;
   logic                      digit_we;
   logic [CNT_BITS-1:0]       cnt_dec;
   logic [IDX_BITS-1:0]       rd_idx;
   logic [WORD_BITS-1:0]      in_mag;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign radix_ok = (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX);
   assign in_mag   = req_value[WORD_BITS-1] ? (~req_value + WORD_BITS'(1)) : req_value;

   // shared restoring divide step: one quotient bit per cycle
   assign trial      = {rem_ff, quo_ff[WORD_BITS-1]};
   assign ge         = (trial >= {1'b0, radix_ff});
   assign diff       = trial - {1'b0, radix_ff};
   assign digit_val  = ge ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
   assign digit_done = (bit_ff == IDX_BITS'(WORD_BITS - 1));
   assign cnt_dec    = cnt_ff - CNT_BITS'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      digit_we     = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_char_in  = NUL_CHAR;
      rsp_last_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               quo_in = in_mag;
               rem_in = '0;
               bit_in = '0;
               cnt_in = '0;
               neg_in = req_value[WORD_BITS-1];
               state_in = radix_ok ? ST_DIVIDE : ST_TERM;
            end
         end
         ST_DIVIDE: begin
            rem_in = digit_val;
            quo_in = {quo_ff[WORD_BITS-2:0], ge};
            bit_in = bit_ff + IDX_BITS'(1);
            if (digit_done) begin
               digit_we = 1'b1;
               cnt_in   = cnt_ff + CNT_BITS'(1);
               bit_in   = '0;
               if (quo_in == '0) begin
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end else begin
                  rem_in = '0;
               end
            end
         end
         ST_SIGN: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = SIGN_CHAR;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = digit_char(digit_ff);
            cnt_in       = cnt_dec;
            if (cnt_dec == '0) begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = NUL_CHAR;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         bit_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         bit_ff       <= bit_in;
         if (csr_write_enable) begin
            radix_ff <= csr_write_data;
         end
      end
   end

   // datapath and output beat registers
   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // digit store, least significant digit first; read one digit ahead
   assign rd_idx = cnt_in[IDX_BITS-1:0] - IDX_BITS'(1);

   always_ff @(posedge clock) begin
      if (digit_we) begin
         digit_mem[cnt_ff[IDX_BITS-1:0]] <= digit_val;
      end
      digit_ff <= digit_we ? digit_val : digit_mem[rd_idx];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // checks
   a_last_is_nul: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_char_ff == NUL_CHAR)
      else $error("last beat is not the terminator");

   a_last_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> state_ff == ST_IDLE)
      else $error("sequencer not idle after terminator");

   a_bad_radix_term: assert property (@(posedge clock) disable iff (reset)
      accept && !radix_ok |=> state_ff == ST_TERM)
      else $error("invalid base did not go straight to terminator");

   a_no_beat_dividing: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> !rsp_valid_ff)
      else $error("beat issued while dividing");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(WORD_BITS))
      else $error("digit count overflow");

endmodule
